// ----- hdl/slot_reservation_calendar_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Slot reservation calendar assertion macros
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SLOT_RESERVATION_CALENDAR_UNIT_DEFINES_SVH
`define SLOT_RESERVATION_CALENDAR_UNIT_DEFINES_SVH

// same-cycle implication
`define SRCAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srcal assertion failed");

// next-cycle implication
`define SRCAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srcal assertion failed");

`endif

// ----- hdl/srcal_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot reservation calendar package
// Request mode codes and the ring command bundle.
// ----------------------------------------------------------------------------
package srcal_pkg;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_RESERVE = 2'd1;
  localparam logic [1:0] MODE_CHECK   = 2'd2;

  // command from the sequencer to the cell ring
  typedef struct packed {
    logic shift;  // every cell takes its neighbor's count
    logic clear;  // tail is refilled with an empty slot
    logic add;    // tail gets head count plus party size
  } ring_cmd_t;

endpackage

// ----- hdl/srcal_if.sv -----
// ----------------------------------------------------------------------------
// Slot reservation calendar channel interfaces
// Valid/ready request and result channels.
// ----------------------------------------------------------------------------
interface srcal_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] start_slot;
  logic [5:0] length;
  logic [7:0] party_size;

  modport source (output valid, mode, start_slot, length, party_size, input ready);
  modport sink   (input valid, mode, start_slot, length, party_size, output ready);
endinterface

interface srcal_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] retired_count;

  modport source (output valid, accepted, retired_count, input ready);
  modport sink   (input valid, accepted, retired_count, output ready);
endinterface

// ----- hdl/srcal_cell.sv -----
// ----------------------------------------------------------------------------
// Slot reservation calendar cell
// Holds one slot's occupancy count and passes it on when the ring shifts.
// ----------------------------------------------------------------------------
module srcal_cell #(
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic [COUNT_BITS-1:0] data_i,
  output logic [COUNT_BITS-1:0] data_o
);

  logic [COUNT_BITS-1:0] count_q, count_d;

  assign count_d = shift_i ? data_i : count_q;
  assign data_o  = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ----- hdl/srcal_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot reservation calendar sequencer
// Walks the ring for capacity check and commit, holds config and result.
// ----------------------------------------------------------------------------
`include "slot_reservation_calendar_unit_defines.svh"

module srcal_ctrl
  import srcal_pkg::*;
#(
  parameter int NUM_SLOTS  = 48,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srcal_req_if.sink             req,
  srcal_rsp_if.source           rsp,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic [COUNT_BITS-1:0] head_i,
  output ring_cmd_t             cmd_o,
  output logic [7:0]            party_o
);

  localparam int KW = $clog2(NUM_SLOTS);
  localparam int IW = ($clog2(NUM_SLOTS) + 1 > 7) ? $clog2(NUM_SLOTS) + 1 : 7;
  localparam int SW = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;
  localparam logic [KW-1:0] K_LAST    = KW'(NUM_SLOTS - 1);
  localparam logic [IW-1:0] N_SLOTS   = IW'(NUM_SLOTS);
  localparam logic [SW-1:0] COUNT_MAX = (SW'(1) << COUNT_BITS) - SW'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_COMMIT, ST_DONE} state_e;

  state_e        state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0]    mode_q, mode_d;
  logic [5:0]    start_q, start_d;
  logic [5:0]    len_q, len_d;
  logic [7:0]    party_q, party_d;
  logic          fail_q, fail_d;
  logic          acc_q, acc_d;
  logic [7:0]    ret_q, ret_d;
  logic [7:0]    cap_q, cap_d;
  logic          out_valid_q, out_valid_d;
  logic          out_acc_q, out_acc_d;
  logic [7:0]    out_ret_q, out_ret_d;

  logic [IW-1:0] k_ext, start_ext, end_ext;
  logic          window_ok, in_win, ok;
  logic [SW-1:0] head_ext, sum, cap_ext, limit;

  assign k_ext     = IW'(k_q);
  assign start_ext = IW'(start_q);
  assign end_ext   = IW'(start_q) + IW'(len_q);
  assign window_ok = (start_ext < N_SLOTS) && (end_ext <= N_SLOTS);
  assign in_win    = (k_ext >= start_ext) && (k_ext < end_ext);

  assign head_ext = SW'(head_i);
  assign sum      = head_ext + SW'(party_q);
  assign cap_ext  = SW'(cap_q);
  assign limit    = (cap_ext > COUNT_MAX) ? COUNT_MAX : cap_ext;

  assign req.ready         = (state_q == ST_IDLE);
  assign rsp.valid         = out_valid_q;
  assign rsp.accepted      = out_acc_q;
  assign rsp.retired_count = out_ret_q;
  assign party_o           = party_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    mode_d      = mode_q;
    start_d     = start_q;
    len_d       = len_q;
    party_d     = party_q;
    fail_d      = fail_q;
    acc_d       = acc_q;
    ret_d       = ret_q;
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_ret_d   = out_ret_q;
    ok          = 1'b0;
    cmd_o       = '0;

    if (rsp.valid && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          mode_d  = req.mode;
          start_d = req.start_slot;
          len_d   = req.length;
          party_d = req.party_size;
          k_d     = '0;
          fail_d  = 1'b0;
          case (req.mode)
            MODE_TICK: begin
              // head is the oldest slot; it moves to the tail as an empty slot
              cmd_o.shift = 1'b1;
              cmd_o.clear = 1'b1;
              acc_d       = 1'b0;
              ret_d       = head_ext[7:0];
              state_d     = ST_DONE;
            end
            MODE_RESERVE, MODE_CHECK: begin
              state_d = ST_CHECK;
            end
            default: begin
              acc_d   = 1'b0;
              ret_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CHECK: begin
        cmd_o.shift = 1'b1;
        if (in_win && (sum > limit)) begin
          fail_d = 1'b1;
        end
        if (k_q == K_LAST) begin
          ok    = window_ok && !fail_d;
          acc_d = ok;
          ret_d = '0;
          k_d   = '0;
          if (ok && (mode_q == MODE_RESERVE) && (len_q != '0)) begin
            state_d = ST_COMMIT;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_COMMIT: begin
        cmd_o.shift = 1'b1;
        cmd_o.add   = in_win;
        if (k_q == K_LAST) begin
          k_d     = '0;
          state_d = ST_DONE;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_ret_d   = ret_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      fail_q      <= 1'b0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_TICK;
      start_q     <= '0;
      len_q       <= '0;
      party_q     <= '0;
      acc_q       <= 1'b0;
      ret_q       <= '0;
      out_acc_q   <= 1'b0;
      out_ret_q   <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      fail_q      <= fail_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      start_q     <= start_d;
      len_q       <= len_d;
      party_q     <= party_d;
      acc_q       <= acc_d;
      ret_q       <= ret_d;
      out_acc_q   <= out_acc_d;
      out_ret_q   <= out_ret_d;
    end
  end

  `SRCAL_ASSERT_NXT(a_tick_done, clk_i, rst_ni,
    req.valid && req.ready && (req.mode == MODE_TICK), (state_q == ST_DONE) && !acc_q)
  `SRCAL_ASSERT_IMP(a_commit_fits, clk_i, rst_ni,
    state_q == ST_COMMIT, acc_q && (mode_q == MODE_RESERVE) && window_ok)
  `SRCAL_ASSERT_IMP(a_accept_no_retire, clk_i, rst_ni,
    out_valid_q && out_acc_q, out_ret_q == '0)
  `SRCAL_ASSERT_NXT(a_commit_ends, clk_i, rst_ni,
    (state_q == ST_COMMIT) && (k_q == K_LAST), state_q == ST_DONE)

endmodule

// ----- hdl/slot_reservation_calendar_unit.sv -----
// Sequencing: a tick goes straight from idle to done; a check or a reserve walks
//   the full ring once in the check state, a committed reserve walks it again in
//   the commit state; done registers the result once the output slot is free.
// Requests: a new one is taken only in idle, after the last result is registered.
// Reset: all slot counts, room capacity and control state clear at once.
// ----------------------------------------------------------------------------
// Slot reservation calendar unit
// Ring of count cells with the oldest slot at the head, walked by a sequencer.
// ----------------------------------------------------------------------------
module slot_reservation_calendar_unit
  import srcal_pkg::*;
#(
  parameter int NUM_SLOTS  = 48,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srcal_req_if.sink   in_i,
  srcal_rsp_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int SW = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;

  ring_cmd_t             cmd;
  logic [7:0]            party;
  logic [COUNT_BITS-1:0] ring [NUM_SLOTS];
  logic [COUNT_BITS-1:0] feedback;
  logic [SW-1:0]         add_sum;

  assign add_sum = SW'(ring[0]) + SW'(party);

  always_comb begin
    if (cmd.clear) begin
      feedback = '0;
    end else if (cmd.add) begin
      feedback = add_sum[COUNT_BITS-1:0];
    end else begin
      feedback = ring[0];
    end
  end

  // cell 0 is the oldest slot; the ring shifts toward it
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == NUM_SLOTS - 1) begin : g_tail
      srcal_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(cmd.shift),
        .data_i (feedback),
        .data_o (ring[i])
      );
    end else begin : g_body
      srcal_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(cmd.shift),
        .data_i (ring[i+1]),
        .data_o (ring[i])
      );
    end
  end

  srcal_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (in_i),
    .rsp        (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .head_i     (ring[0]),
    .cmd_o      (cmd),
    .party_o    (party)
  );

endmodule
